// ===== sv/urt_pkg.sv =====
// ----------------------------------------------------------------------------
// urt_pkg
// Shared types and constants of the ultrasonic range trigger: phase codes,
// register indexes, the configuration bundle and the result bundle.
// ----------------------------------------------------------------------------
package urt_pkg;

  localparam int unsigned TickW   = 24;
  localparam int unsigned TrigW   = 8;
  localparam int unsigned DistW   = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  // Distance scale: width * 281 / 1024 gives sixteenths of a centimetre.
  localparam int unsigned DistMul   = 281;
  localparam int unsigned DistMulW  = 9;
  localparam int unsigned DistShift = 10;
  localparam logic [DistW-1:0] DistMax = 15'h7FFF;

  localparam logic [TickW-1:0] PeriodReset    = 24'd100000;
  localparam logic [TrigW-1:0] TrigReset      = 8'd20;
  localparam logic [DistW-1:0] ThresholdReset = 15'd112;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD    = 2'd0,
    REG_TRIGGER   = 2'd1,
    REG_THRESHOLD = 2'd2
  } urt_reg_t;

  typedef enum logic [3:0] {
    PH_WAIT      = 4'b0001,
    PH_TRIG      = 4'b0010,
    PH_ECHO_WAIT = 4'b0100,
    PH_ECHO_HIGH = 4'b1000
  } urt_phase_t;

  typedef struct packed {
    logic [TickW-1:0] period_ticks;
    logic [TrigW-1:0] trigger_ticks;
    logic [DistW-1:0] shoot_threshold;
  } urt_cfg_t;

  typedef struct packed {
    logic             trigger_level;
    logic             done_res;
    logic [DistW-1:0] distance;
    logic             distance_report;
    logic             shoot;
  } urt_res_t;

endpackage

// ===== sv/urt_core.sv =====
// ----------------------------------------------------------------------------
// urt_core
// Ranging sequencer: idle period, trigger pulse, echo wait and echo width
// count. Advances by one tick on each step and produces that tick's result.
// ----------------------------------------------------------------------------
module urt_core #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              echo_level,
  input  logic              enable,
  input  urt_pkg::urt_cfg_t cfg,
  output urt_pkg::urt_res_t res
);

  localparam int unsigned ProdW = WIDTH_BITS + urt_pkg::DistMulW;
  localparam int unsigned QuotW = ProdW - urt_pkg::DistShift;

  urt_pkg::urt_phase_t         phase_r, phase_nxt;
  logic [urt_pkg::TickW-1:0]   tick_r, tick_nxt;
  logic [WIDTH_BITS-1:0]       width_r, width_nxt;

  logic [urt_pkg::TickW-1:0]   tick_inc;
  logic [ProdW-1:0]            prod;
  logic [QuotW-1:0]            dist_full;
  logic [urt_pkg::DistW-1:0]   dist_sat;

  assign tick_inc  = tick_r + urt_pkg::TickW'(1);
  assign prod      = ProdW'(width_r) * ProdW'(urt_pkg::DistMul);
  assign dist_full = prod[ProdW-1:urt_pkg::DistShift];

  // Only wide echo counters can exceed the 15-bit distance range.
  assign dist_sat = (ProdW'(dist_full) > ProdW'(urt_pkg::DistMax)) ?
                    urt_pkg::DistMax : urt_pkg::DistW'(dist_full);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    width_nxt = width_r;
    res       = '0;
    unique case (phase_r)
      urt_pkg::PH_WAIT: begin
        if (tick_inc >= cfg.period_ticks) begin
          phase_nxt = urt_pkg::PH_TRIG;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      urt_pkg::PH_TRIG: begin
        res.trigger_level = 1'b1;
        if (tick_inc >= urt_pkg::TickW'(cfg.trigger_ticks)) begin
          phase_nxt = urt_pkg::PH_ECHO_WAIT;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      urt_pkg::PH_ECHO_WAIT: begin
        if (echo_level) begin
          width_nxt = WIDTH_BITS'(1);
          phase_nxt = urt_pkg::PH_ECHO_HIGH;
        end
      end
      urt_pkg::PH_ECHO_HIGH: begin
        if (echo_level) begin
          if (width_r != {WIDTH_BITS{1'b1}}) begin
            width_nxt = width_r + WIDTH_BITS'(1);
          end
        end else begin
          res.done_res        = 1'b1;
          res.distance        = dist_sat;
          res.distance_report = enable;
          res.shoot           = enable && (dist_sat < cfg.shoot_threshold);
          phase_nxt           = urt_pkg::PH_WAIT;
          tick_nxt            = '0;
        end
      end
      default: begin
        phase_nxt = urt_pkg::PH_WAIT;
        tick_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urt_pkg::PH_WAIT;
      tick_r  <= '0;
      width_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      width_r <= width_nxt;
    end
  end

endmodule

// ===== sv/ultrasonic_range_trigger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_range_trigger
// Tick-driven controller for an ultrasonic ranging sensor with a shoot flag.
// ----------------------------------------------------------------------------
// Each input item is one microsecond tick carrying the sampled echo level and
// the enable bit; each tick yields exactly one result item with the trigger
// level for that tick and, on the tick the echo falls, the distance in
// sixteenths of a centimetre with the report and shoot flags.
// Both channels use valid/stall: an item moves at a clock edge where valid is
// high and stall is low. An accepted item is held in the input register until
// the output register is free; then the sequencer steps and the result is
// loaded into the output register, where out_valid marks it until it is taken.
// The sequencer takes one tick per cycle, so one item per cycle is sustained
// while the receiver keeps up.
// If the receiver stalls, the output register holds its result and the input
// register keeps the next item; in_stall rises only when both are occupied
// and the receiver stalls.
// Configuration writes go through cfg_we/cfg_index/cfg_data and should be
// made while no item is in flight. Synchronous reset restores the register
// defaults, empties both stages and starts the idle period from zero.
// ----------------------------------------------------------------------------
module ultrasonic_range_trigger #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_echo_level,
  input  logic                          in_enable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trigger_level,
  output logic                          out_done_res,
  output logic [urt_pkg::DistW-1:0]     out_distance,
  output logic                          out_distance_report,
  output logic                          out_shoot,
  input  logic                          cfg_we,
  input  logic [urt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [urt_pkg::CfgW-1:0]      cfg_data
);

  urt_pkg::urt_cfg_t cfg_r;

  logic              s1_valid_r;
  logic              s1_echo_r;
  logic              s1_enable_r;
  logic              out_valid_r;
  urt_pkg::urt_res_t out_res_r;
  urt_pkg::urt_res_t core_res;

  logic out_free;
  logic s1_adv;
  logic in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ticks    <= urt_pkg::PeriodReset;
      cfg_r.trigger_ticks   <= urt_pkg::TrigReset;
      cfg_r.shoot_threshold <= urt_pkg::ThresholdReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urt_pkg::REG_PERIOD:    cfg_r.period_ticks    <= cfg_data;
        urt_pkg::REG_TRIGGER:   cfg_r.trigger_ticks   <= cfg_data[urt_pkg::TrigW-1:0];
        urt_pkg::REG_THRESHOLD: cfg_r.shoot_threshold <= cfg_data[urt_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_echo_r   <= in_echo_level;
      s1_enable_r <= in_enable;
    end
  end

  urt_core #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .echo_level (s1_echo_r),
    .enable     (s1_enable_r),
    .cfg        (cfg_r),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_trigger_level   = out_res_r.trigger_level;
  assign out_done_res        = out_res_r.done_res;
  assign out_distance        = out_res_r.distance;
  assign out_distance_report = out_res_r.distance_report;
  assign out_shoot           = out_res_r.shoot;

endmodule

// ===== sv/urt_checker.sv =====
// ----------------------------------------------------------------------------
// urt_checker
// Port-level checks of the ultrasonic range trigger, bound to the top level.
// ----------------------------------------------------------------------------
module urt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_trigger_level,
  input logic                      out_done_res,
  input logic [urt_pkg::DistW-1:0] out_distance,
  input logic                      out_distance_report,
  input logic                      out_shoot
);

  // A stalled result keeps its place, its distance and its done and shoot flags.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance) &&
      $stable(out_done_res) && $stable(out_shoot))
    else $error("stalled result changed");

  // Shoot is only raised on a published measurement.
  a_shoot_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shoot |-> out_distance_report && out_done_res)
    else $error("shoot without report");

  // A report only comes with a completed measurement.
  a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance_report |-> out_done_res)
    else $error("report without done");

  // The trigger is never high on the tick a measurement completes.
  a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_trigger_level)
    else $error("trigger high on done tick");

  // Outside a completed measurement the distance reads zero.
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_distance == '0)
    else $error("distance set without done");

endmodule

bind ultrasonic_range_trigger urt_checker u_urt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_trigger_level   (out_trigger_level),
  .out_done_res        (out_done_res),
  .out_distance        (out_distance),
  .out_distance_report (out_distance_report),
  .out_shoot           (out_shoot)
);
